/* hw/rtl/bfa_pkg.sv */
// ----------------------------------------------------------------------------
// bfa_pkg
// shared types and codes of the bitmap frame allocator
// ----------------------------------------------------------------------------
package bfa_pkg;

    localparam int KIND_W   = 2;
    localparam int INDEX_W  = 12;
    localparam int COUNT_W  = 13;
    localparam int STATUS_W = 2;
    localparam int START_W  = 12;
    localparam int CFG_W    = 13;

    localparam logic [CFG_W-1:0] FRAMES_MANAGED_RST = 13'd4096;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FREE    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_RESERVE = 2'd3;

    // result codes
    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_RUN   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_USED = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_RANGE    = 2'd3;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SEARCH,
        ST_MARK,
        ST_RESULT
    } state_t;

    // per-word control of the word unit
    typedef struct packed {
        logic lim_word;
        logic first_word;
        logic last_word;
        logic set_bits;
    } unit_ctl_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [START_W-1:0]  start;
    } res_t;

endpackage

/* hw/rtl/bfa_map_mem.sv */
// ----------------------------------------------------------------------------
// bfa_map_mem
// used-bit map storage, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module bfa_map_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 64,
    parameter int AW    = 6
) (
    input  logic             clk,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* hw/rtl/bfa_word_unit.sv */
// ----------------------------------------------------------------------------
// bfa_word_unit
// shared per-word unit: first-fit run search and range mask update
// ----------------------------------------------------------------------------
module bfa_word_unit #(
    parameter int MAX_FRAMES = 4096,
    parameter int WORD_BITS  = 64,
    localparam int LW  = $clog2(WORD_BITS),
    localparam int FW0 = $clog2(MAX_FRAMES + 1),
    localparam int FW  = (FW0 > 14) ? FW0 : 14
) (
    input  bfa_pkg::unit_ctl_t      ctl,
    input  logic [WORD_BITS-1:0]    map_word,
    input  logic [FW-1:0]           base,
    input  logic [FW-1:0]           carry_len,
    input  logic [FW-1:0]           carry_start,
    input  logic [FW-1:0]           cnt,
    input  logic [LW-1:0]           lim_bit,
    input  logic [LW-1:0]           lo_bit,
    input  logic [LW-1:0]           hi_bit,
    output logic                    found,
    output logic [FW-1:0]           found_start,
    output logic [FW-1:0]           next_carry_len,
    output logic [FW-1:0]           next_carry_start,
    output logic [WORD_BITS-1:0]    new_word,
    output logic                    hit
);

    localparam int KW  = $clog2(LW + 1);
    localparam logic [WORD_BITS-1:0] ONES = {WORD_BITS{1'b1}};

    logic [WORD_BITS-1:0] used_bits;
    logic [WORD_BITS-1:0] free_bits;
    logic                 all_free;
    logic [LW:0]          lead;
    logic [LW:0]          trail;
    logic [LW:0]          cnt_low;
    logic [KW-1:0]        lvl_sel;
    logic [LW:0]          lvl_off;
    logic [WORD_BITS-1:0] lvl [LW+1];
    logic [WORD_BITS-1:0] sel_lvl;
    logic [WORD_BITS-1:0] runs;
    logic [LW-1:0]        int_off;
    logic                 int_found;
    logic                 carry_done;
    logic [FW-1:0]        span_start;
    logic [WORD_BITS-1:0] lo_mask;
    logic [WORD_BITS-1:0] hi_mask;
    logic [WORD_BITS-1:0] mark_mask;

    // frames at or above the managed count count as used
    assign used_bits = map_word | (ctl.lim_word ? (ONES << lim_bit) : '0);
    assign free_bits = ~used_bits;
    assign all_free  = ~|used_bits;

    // free bits at the low end and at the high end of the word
    always_comb
    begin
        lead  = (LW+1)'(WORD_BITS);
        trail = (LW+1)'(WORD_BITS);
        for (int j = WORD_BITS - 1; j >= 0; j--)
        begin
            if (used_bits[j])
            begin
                lead = (LW+1)'(j);
            end
        end
        for (int j = 0; j < WORD_BITS; j++)
        begin
            if (used_bits[j])
            begin
                trail = (LW+1)'(WORD_BITS - 1 - j);
            end
        end
    end

    // run length split into a power of two and a remainder
    assign cnt_low = cnt[LW:0];

    always_comb
    begin
        lvl_sel = '0;
        for (int j = 0; j <= LW; j++)
        begin
            if (cnt_low[j])
            begin
                lvl_sel = KW'(j);
            end
        end
    end

    assign lvl_off = cnt_low & ~((LW+1)'(1) << lvl_sel);

    // lvl[k] bit j: frames j .. j + 2^k - 1 all free
    always_comb
    begin
        lvl[0] = free_bits;
        for (int k = 1; k <= LW; k++)
        begin
            lvl[k] = lvl[k-1] & (lvl[k-1] >> (1 << (k - 1)));
        end
    end

    assign sel_lvl   = lvl[lvl_sel];
    assign runs      = sel_lvl & (sel_lvl >> lvl_off);
    assign int_found = (cnt <= FW'(WORD_BITS)) && (|runs);

    always_comb
    begin
        int_off = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--)
        begin
            if (runs[j])
            begin
                int_off = LW'(j);
            end
        end
    end

    // run carried in from lower words, completed by the low free bits
    assign span_start = (carry_len == '0) ? base : carry_start;
    assign carry_done = (carry_len + FW'(lead)) >= cnt;

    assign found       = carry_done | int_found;
    assign found_start = carry_done ? span_start : (base + FW'(int_off));

    assign next_carry_len   = all_free ? (carry_len + FW'(WORD_BITS)) : FW'(trail);
    assign next_carry_start = all_free ? span_start
                                       : (base + FW'(WORD_BITS) - FW'(trail));

    // range mask for set and clear
    assign lo_mask   = ctl.first_word ? (ONES << lo_bit) : ONES;
    assign hi_mask   = ctl.last_word ? (ONES >> (LW'(WORD_BITS - 1) - hi_bit)) : ONES;
    assign mark_mask = lo_mask & hi_mask;
    assign new_word  = ctl.set_bits ? (map_word | mark_mask) : (map_word & ~mark_mask);
    assign hit       = |(map_word & mark_mask);

endmodule

/* hw/rtl/bfa_seq.sv */
// ----------------------------------------------------------------------------
// bfa_seq
// request sequencer: clearing pass, word-serial search and range marking
// ----------------------------------------------------------------------------
module bfa_seq #(
    parameter int MAX_FRAMES = 4096,
    parameter int WORD_BITS  = 64,
    localparam int LW        = $clog2(WORD_BITS),
    localparam int FW0       = $clog2(MAX_FRAMES + 1),
    localparam int FW        = (FW0 > 14) ? FW0 : 14,
    localparam int MAP_WORDS = MAX_FRAMES / WORD_BITS,
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_ready,
    input  logic [bfa_pkg::KIND_W-1:0]     req_kind,
    input  logic [bfa_pkg::INDEX_W-1:0]    req_index,
    input  logic [bfa_pkg::COUNT_W-1:0]    req_count,
    input  logic                           cfg_we,
    input  logic [bfa_pkg::CFG_W-1:0]      cfg_wdata,
    output logic                           res_valid,
    input  logic                           res_ready,
    output bfa_pkg::res_t                  res,
    output logic                           mem_rd_en,
    output logic [AW-1:0]                  mem_rd_addr,
    input  logic [WORD_BITS-1:0]           mem_rd_data,
    output logic                           mem_wr_en,
    output logic [AW-1:0]                  mem_wr_addr,
    output logic [WORD_BITS-1:0]           mem_wr_data
);

    bfa_pkg::state_t state_reg, state_next;

    logic [AW-1:0]                  clr_addr_reg, clr_addr_next;
    logic [bfa_pkg::CFG_W-1:0]      fm_reg;
    logic [FW-1:0]                  lim_reg, lim_next;
    logic [FW-1:0]                  cnt_reg, cnt_next;
    logic [FW-1:0]                  rng_start_reg, rng_start_next;
    logic [FW-1:0]                  rng_last_reg, rng_last_next;
    logic                           set_reg, set_next;
    logic                           check_reg, check_next;
    logic [FW-1:0]                  rd_word_reg, rd_word_next;
    logic [FW-1:0]                  proc_word_reg, proc_word_next;
    logic                           pend_reg, pend_next;
    logic [FW-1:0]                  end_word_reg, end_word_next;
    logic [FW-1:0]                  carry_len_reg, carry_len_next;
    logic [FW-1:0]                  carry_start_reg, carry_start_next;
    logic [bfa_pkg::STATUS_W-1:0]   status_reg, status_next;
    logic [FW-1:0]                  start_reg, start_next;

    logic [FW-1:0]                  fm_ext;
    logic [FW-1:0]                  lim_now;
    logic [FW-1:0]                  idx_ext;
    logic [FW-1:0]                  cnt_ext;
    logic [FW-1:0]                  rng_sum;
    logic                           accept;
    logic                           alloc_bad;
    logic                           free_bad;
    logic                           range_bad;
    logic                           range_empty;
    logic                           at_end;
    logic                           issue;

    bfa_pkg::unit_ctl_t             u_ctl;
    logic [FW-1:0]                  u_base;
    logic                           u_found;
    logic [FW-1:0]                  u_start;
    logic [FW-1:0]                  u_carry_len;
    logic [FW-1:0]                  u_carry_start;
    logic [WORD_BITS-1:0]           u_word;
    logic                           u_hit;
    logic [FW-1:0]                  found_last;

    assign fm_ext  = FW'(fm_reg);
    assign lim_now = (fm_ext > FW'(MAX_FRAMES)) ? FW'(MAX_FRAMES) : fm_ext;
    assign idx_ext = FW'(req_index);
    assign cnt_ext = FW'(req_count);
    assign rng_sum = idx_ext + cnt_ext;

    assign req_ready   = (state_reg == bfa_pkg::ST_IDLE);
    assign accept      = req_ready && req_valid;
    assign alloc_bad   = (cnt_ext == '0) || (cnt_ext > lim_now);
    assign free_bad    = (idx_ext >= lim_now);
    assign range_bad   = (rng_sum > lim_now);
    assign range_empty = (cnt_ext == '0);
    assign at_end      = (proc_word_reg == end_word_reg);
    assign issue       = (rd_word_reg <= end_word_reg);

    // shared word unit
    assign u_base           = proc_word_reg << LW;
    assign u_ctl.lim_word   = (proc_word_reg == (lim_reg >> LW));
    assign u_ctl.first_word = (proc_word_reg == (rng_start_reg >> LW));
    assign u_ctl.last_word  = at_end;
    assign u_ctl.set_bits   = set_reg;

    bfa_word_unit #(
        .MAX_FRAMES (MAX_FRAMES),
        .WORD_BITS  (WORD_BITS)
    ) u_unit (
        .ctl              (u_ctl),
        .map_word         (mem_rd_data),
        .base             (u_base),
        .carry_len        (carry_len_reg),
        .carry_start      (carry_start_reg),
        .cnt              (cnt_reg),
        .lim_bit          (lim_reg[LW-1:0]),
        .lo_bit           (rng_start_reg[LW-1:0]),
        .hi_bit           (rng_last_reg[LW-1:0]),
        .found            (u_found),
        .found_start      (u_start),
        .next_carry_len   (u_carry_len),
        .next_carry_start (u_carry_start),
        .new_word         (u_word),
        .hit              (u_hit)
    );

    assign found_last = u_start + cnt_reg - FW'(1);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bfa_pkg::ST_CLEAR:
            begin
                if (clr_addr_reg == AW'(MAP_WORDS - 1))
                begin
                    state_next = bfa_pkg::ST_IDLE;
                end
            end
            bfa_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (req_kind)
                        bfa_pkg::KIND_ALLOC:
                        begin
                            state_next = alloc_bad ? bfa_pkg::ST_RESULT : bfa_pkg::ST_SEARCH;
                        end
                        bfa_pkg::KIND_FREE:
                        begin
                            state_next = free_bad ? bfa_pkg::ST_RESULT : bfa_pkg::ST_MARK;
                        end
                        default:
                        begin
                            state_next = (range_bad || range_empty) ? bfa_pkg::ST_RESULT
                                                                    : bfa_pkg::ST_MARK;
                        end
                    endcase
                end
            end
            bfa_pkg::ST_SEARCH:
            begin
                if (pend_reg && u_found)
                begin
                    state_next = bfa_pkg::ST_MARK;
                end
                else if (pend_reg && at_end)
                begin
                    state_next = bfa_pkg::ST_RESULT;
                end
            end
            bfa_pkg::ST_MARK:
            begin
                if (pend_reg && ((check_reg && !u_hit) || at_end))
                begin
                    state_next = bfa_pkg::ST_RESULT;
                end
            end
            bfa_pkg::ST_RESULT:
            begin
                if (res_ready)
                begin
                    state_next = bfa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bfa_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        clr_addr_next    = clr_addr_reg;
        lim_next         = lim_reg;
        cnt_next         = cnt_reg;
        rng_start_next   = rng_start_reg;
        rng_last_next    = rng_last_reg;
        set_next         = set_reg;
        check_next       = check_reg;
        rd_word_next     = rd_word_reg;
        proc_word_next   = proc_word_reg;
        pend_next        = pend_reg;
        end_word_next    = end_word_reg;
        carry_len_next   = carry_len_reg;
        carry_start_next = carry_start_reg;
        status_next      = status_reg;
        start_next       = start_reg;
        mem_rd_en        = 1'b0;
        mem_rd_addr      = rd_word_reg[AW-1:0];
        mem_wr_en        = 1'b0;
        mem_wr_addr      = proc_word_reg[AW-1:0];
        mem_wr_data      = u_word;
        res_valid        = 1'b0;

        case (state_reg)
            bfa_pkg::ST_CLEAR:
            begin
                mem_wr_en     = 1'b1;
                mem_wr_addr   = clr_addr_reg;
                mem_wr_data   = '1;
                clr_addr_next = clr_addr_reg + AW'(1);
            end
            bfa_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    lim_next         = lim_now;
                    cnt_next         = cnt_ext;
                    pend_next        = 1'b0;
                    carry_len_next   = '0;
                    carry_start_next = '0;
                    status_next      = bfa_pkg::STATUS_OK;
                    start_next       = '0;
                    case (req_kind)
                        bfa_pkg::KIND_ALLOC:
                        begin
                            if (alloc_bad)
                            begin
                                status_next = bfa_pkg::STATUS_NO_RUN;
                            end
                            rd_word_next  = '0;
                            end_word_next = (lim_now - FW'(1)) >> LW;
                        end
                        bfa_pkg::KIND_FREE:
                        begin
                            if (free_bad)
                            begin
                                status_next = bfa_pkg::STATUS_RANGE;
                            end
                            rng_start_next = idx_ext;
                            rng_last_next  = idx_ext;
                            set_next       = 1'b0;
                            check_next     = 1'b1;
                            rd_word_next   = idx_ext >> LW;
                            end_word_next  = idx_ext >> LW;
                        end
                        default:
                        begin
                            if (range_bad)
                            begin
                                status_next = bfa_pkg::STATUS_RANGE;
                            end
                            rng_start_next = idx_ext;
                            rng_last_next  = rng_sum - FW'(1);
                            set_next       = (req_kind == bfa_pkg::KIND_RESERVE);
                            check_next     = 1'b0;
                            rd_word_next   = idx_ext >> LW;
                            end_word_next  = (rng_sum - FW'(1)) >> LW;
                        end
                    endcase
                end
            end
            bfa_pkg::ST_SEARCH:
            begin
                mem_rd_en      = issue;
                pend_next      = issue;
                proc_word_next = rd_word_reg;
                if (issue)
                begin
                    rd_word_next = rd_word_reg + FW'(1);
                end
                if (pend_reg)
                begin
                    if (u_found)
                    begin
                        // run found: mark it used
                        start_next     = u_start;
                        rng_start_next = u_start;
                        rng_last_next  = found_last;
                        set_next       = 1'b1;
                        check_next     = 1'b0;
                        rd_word_next   = u_start >> LW;
                        end_word_next  = found_last >> LW;
                        pend_next      = 1'b0;
                    end
                    else
                    begin
                        carry_len_next   = u_carry_len;
                        carry_start_next = u_carry_start;
                        if (at_end)
                        begin
                            status_next = bfa_pkg::STATUS_NO_RUN;
                        end
                    end
                end
            end
            bfa_pkg::ST_MARK:
            begin
                mem_rd_en      = issue;
                pend_next      = issue;
                proc_word_next = rd_word_reg;
                if (issue)
                begin
                    rd_word_next = rd_word_reg + FW'(1);
                end
                if (pend_reg)
                begin
                    if (check_reg && !u_hit)
                    begin
                        status_next = bfa_pkg::STATUS_NOT_USED;
                    end
                    else
                    begin
                        mem_wr_en = 1'b1;
                    end
                end
            end
            bfa_pkg::ST_RESULT:
            begin
                res_valid = 1'b1;
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    assign res.status = status_reg;
    assign res.start  = start_reg[bfa_pkg::START_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= bfa_pkg::ST_CLEAR;
            clr_addr_reg <= '0;
            pend_reg     <= 1'b0;
            fm_reg       <= bfa_pkg::FRAMES_MANAGED_RST;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            pend_reg     <= pend_next;
            if (cfg_we)
            begin
                fm_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lim_reg         <= lim_next;
        cnt_reg         <= cnt_next;
        rng_start_reg   <= rng_start_next;
        rng_last_reg    <= rng_last_next;
        set_reg         <= set_next;
        check_reg       <= check_next;
        rd_word_reg     <= rd_word_next;
        proc_word_reg   <= proc_word_next;
        end_word_reg    <= end_word_next;
        carry_len_reg   <= carry_len_next;
        carry_start_reg <= carry_start_next;
        status_reg      <= status_next;
        start_reg       <= start_next;
    end

endmodule

/* hw/rtl/bitmap_frame_allocator.sv */
// ----------------------------------------------------------------------------
// bitmap_frame_allocator
// first-fit page frame allocator over a used-bit map, one map word per cycle
// ----------------------------------------------------------------------------
// latency, accept to result valid, follows the steps: allocate scans map words
//   up to the fitting run, then marks the words the run covers; free handles one
//   word, release and reserve the words covered, a rejected or empty request none
// throughput: one request at a time, the next taken in the cycle after the result
//   is handed on
// reset: frames_managed 4096, every frame marked used by a clearing pass
// ----------------------------------------------------------------------------
module bitmap_frame_allocator #(
    parameter int MAX_FRAMES = 4096,
    parameter int WORD_BITS  = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    // request: tdata = frame_index[11:0], length[24:12], zero pad
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,
    // request: tuser = kind[1:0]
    input  logic [1:0]  s_axis_tuser,
    // result: tdata = status[1:0], start_frame[13:2], zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,
    // frames_managed register write
    input  logic        cfg_we,
    input  logic [12:0] cfg_wdata
);

    localparam int MAP_WORDS = MAX_FRAMES / WORD_BITS;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

    logic                   mem_rd_en;
    logic [AW-1:0]          mem_rd_addr;
    logic [WORD_BITS-1:0]   mem_rd_data;
    logic                   mem_wr_en;
    logic [AW-1:0]          mem_wr_addr;
    logic [WORD_BITS-1:0]   mem_wr_data;

    logic                   res_valid;
    logic                   res_ready;
    bfa_pkg::res_t          res;

    // output register parts the result from the sequencer
    logic                   out_valid_reg, out_valid_next;
    bfa_pkg::res_t          out_res_reg, out_res_next;

    // used-bit map, bit set = frame in use
    bfa_map_mem #(
        .DEPTH (MAP_WORDS),
        .WIDTH (WORD_BITS),
        .AW    (AW)
    ) u_map (
        .clk     (clk),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    // sequencer with the shared word unit
    bfa_seq #(
        .MAX_FRAMES (MAX_FRAMES),
        .WORD_BITS  (WORD_BITS)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (s_axis_tvalid),
        .req_ready   (s_axis_tready),
        .req_kind    (s_axis_tuser),
        .req_index   (s_axis_tdata[11:0]),
        .req_count   (s_axis_tdata[24:12]),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data)
    );

    // slot free when empty or being drained this cycle
    assign res_ready = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_res_next   = res;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_res_reg.start, out_res_reg.status};

endmodule

/* sim/bitmap_frame_allocator_test.sv */
// ----------------------------------------------------------------------------
// bitmap_frame_allocator_test
// request-level testbench of the first-fit page frame allocator: requests go in
// over the slave stream, results are checked against a bit-level map kept here
// ----------------------------------------------------------------------------
module bitmap_frame_allocator_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_FRAMES  = 4096;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int PHASE_ITEMS = 260;
    localparam int PRINT_LIMIT = 100;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    // request stream
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;      // frame_index[11:0], length[24:12], zero pad
    logic [1:0]  s_axis_tuser = '0;      // kind[1:0]
    // result stream
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;           // status[1:0], start_frame[13:2], zero pad
    // frames_managed write port
    logic        cfg_we = 1'b0;
    logic [12:0] cfg_wdata = '0;

    // mirror of the block: one bit per frame, set means in use
    logic [NUM_FRAMES-1:0] frames_in_use;
    int                    frames_managed_cfg;

    // expected results, oldest first
    bfa_pkg::res_t pending_results[$];
    // starts of runs handed out, used to aim frees at frames in use
    int   allocated_starts[$];

    bit idling_on;
    int ready_wait;
    int hold_off_left;
    int cycle_count;
    int mismatch_count;
    int requests_sent;
    int results_checked;
    int settings_used;

    bitmap_frame_allocator i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // allocator mirror
    // ------------------------------------------------------------------------

    // works out the result of one request and applies it to the frame map
    function automatic bfa_pkg::res_t predict_request(input logic [1:0] kind,
                                                      input logic [11:0] idx,
                                                      input logic [12:0] cnt);
        int   lim;
        int   span_start;
        int   run_len;
        int   i;
        bit   found;
        bfa_pkg::res_t r;
        // register values above the map size act as the map size
        lim = (frames_managed_cfg > NUM_FRAMES) ? NUM_FRAMES : frames_managed_cfg;
        r.status = bfa_pkg::STATUS_OK;
        r.start = '0;
        found = 1'b0;
        span_start = 0;
        run_len = 0;
        case (kind)
            bfa_pkg::KIND_ALLOC:
            begin
                // first fit from frame 0, zero length never fits
                if (cnt != 0 && int'(cnt) <= lim)
                begin
                    for (i = 0; i < lim && !found; i++)
                    begin
                        if (!frames_in_use[i])
                        begin
                            if (run_len == 0)
                                span_start = i;
                            run_len++;
                            if (run_len == int'(cnt))
                                found = 1'b1;
                        end
                        else
                            run_len = 0;
                    end
                end
                if (found)
                begin
                    for (i = 0; i < int'(cnt); i++)
                        frames_in_use[span_start + i] = 1'b1;
                    r.start = span_start[bfa_pkg::START_W-1:0];
                end
                else
                    r.status = bfa_pkg::STATUS_NO_RUN;
            end
            bfa_pkg::KIND_FREE:
            begin
                if (int'(idx) >= lim)
                    r.status = bfa_pkg::STATUS_RANGE;
                else if (!frames_in_use[idx])
                    r.status = bfa_pkg::STATUS_NOT_USED;
                else
                    frames_in_use[idx] = 1'b0;
            end
            default:
            begin
                // release and reserve: whole range inside the managed frames or nothing
                if (int'(idx) + int'(cnt) > lim)
                    r.status = bfa_pkg::STATUS_RANGE;
                else
                    for (i = 0; i < int'(cnt); i++)
                        frames_in_use[int'(idx) + i] = (kind == bfa_pkg::KIND_RESERVE);
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------------

    // offers one request, after a random gap when idling is on, and records its expected result
    // once the block takes it; valid stays up for back-to-back requests
    task automatic send_request(input logic [1:0] kind, input logic [11:0] idx,
                                input logic [12:0] cnt);
        int   gap;
        bfa_pkg::res_t predicted;
        gap = idling_on ? $urandom_range(0, 12) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, cnt, idx};
        s_axis_tuser  <= kind;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predicted = predict_request(kind, idx, cnt);
        pending_results.push_back(predicted);
        requests_sent++;
        if (kind == bfa_pkg::KIND_ALLOC && predicted.status == bfa_pkg::STATUS_OK &&
            allocated_starts.size() < 256)
            allocated_starts.push_back(int'(predicted.start));
    endtask

    // drops valid and waits for every outstanding result
    task automatic wait_results_drained();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    // register write, only called with the block idle
    task automatic write_frames_managed(input logic [12:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        frames_managed_cfg = int'(value);
        settings_used++;
        allocated_starts.delete();
    endtask

    // ------------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        // one line per mismatch, quiet after the first hundred
        if (mismatch_count < PRINT_LIMIT)
            $display("[%0t] mismatch %0d: %s", $realtime, mismatch_count + 1, what);
        mismatch_count++;
    endtask

    // ready changes on the falling edge: a long hold-off first, then the
    // per-result wait drawn when the previous result was taken
    always @(negedge clk)
    begin
        if (hold_off_left > 0)
        begin
            hold_off_left--;
            m_axis_tready <= 1'b0;
        end
        else if (ready_wait > 0)
        begin
            ready_wait--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    // each result is compared with the oldest expectation
    always @(posedge clk)
    begin : check_results
        bfa_pkg::res_t want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            ready_wait = idling_on ? $urandom_range(0, 12) : 0;
            results_checked++;
            if (pending_results.size() == 0)
                report_mismatch($sformatf("result with no request pending, data 0x%04h",
                                          m_axis_tdata));
            else
            begin
                want = pending_results.pop_front();
                if (m_axis_tdata[1:0] !== want.status)
                    report_mismatch($sformatf("result %0d status got %0d want %0d",
                                              results_checked, m_axis_tdata[1:0],
                                              want.status));
                if (m_axis_tdata[13:2] !== want.start)
                    report_mismatch($sformatf("result %0d start_frame got %0d want %0d",
                                              results_checked, m_axis_tdata[13:2],
                                              want.start));
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still pending",
                     cycle_count, pending_results.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // map all used after reset, register at its reset value
    task automatic test_reset_state();
        idling_on = 1'b1;
        send_request(bfa_pkg::KIND_ALLOC,   12'd0,    13'd1);     // nothing free yet
        send_request(bfa_pkg::KIND_FREE,    12'd4095, 13'd0);     // top frame is in use
        send_request(bfa_pkg::KIND_FREE,    12'd4095, 13'd0);     // double free
        send_request(bfa_pkg::KIND_ALLOC,   12'd0,    13'd1);     // single frame at the top
        send_request(bfa_pkg::KIND_ALLOC,   12'd0,    13'd0);     // zero-length allocation
        send_request(bfa_pkg::KIND_RELEASE, 12'd0,    13'd4096);  // whole map
        send_request(bfa_pkg::KIND_ALLOC,   12'd0,    13'd4096);  // whole map in one run
        send_request(bfa_pkg::KIND_ALLOC,   12'd0,    13'd4097);  // longer than managed
        send_request(bfa_pkg::KIND_RELEASE, 12'd4095, 13'd2);     // range end past the map
        send_request(bfa_pkg::KIND_RELEASE, 12'd100,  13'd0);     // empty range
        send_request(bfa_pkg::KIND_RESERVE, 12'd4095, 13'd8191);  // widest count
        send_request(bfa_pkg::KIND_ALLOC,   12'd0,    13'd8191);
        wait_results_drained();
    endtask

    // register extremes: nothing managed, above the map size, a single frame
    task automatic test_config_extremes();
        write_frames_managed(13'd0);
        send_request(bfa_pkg::KIND_FREE,    12'd0, 13'd0);        // free beyond managed count
        send_request(bfa_pkg::KIND_ALLOC,   12'd0, 13'd1);
        send_request(bfa_pkg::KIND_RELEASE, 12'd0, 13'd0);        // empty range at the limit
        send_request(bfa_pkg::KIND_RESERVE, 12'd0, 13'd1);
        wait_results_drained();
        write_frames_managed(13'd8191);
        send_request(bfa_pkg::KIND_RELEASE, 12'd0,    13'd4096);
        send_request(bfa_pkg::KIND_ALLOC,   12'd0,    13'd4096);
        send_request(bfa_pkg::KIND_FREE,    12'd4095, 13'd0);
        wait_results_drained();
        write_frames_managed(13'd1);
        send_request(bfa_pkg::KIND_FREE,  12'd0, 13'd0);
        send_request(bfa_pkg::KIND_ALLOC, 12'd0, 13'd2);          // run longer than managed
        send_request(bfa_pkg::KIND_ALLOC, 12'd0, 13'd1);
        send_request(bfa_pkg::KIND_FREE,  12'd1, 13'd0);
        wait_results_drained();
    endtask

    // receiver stalls for a long stretch while requests keep coming, so the
    // block holds its result and stops taking requests
    task automatic test_result_backpressure();
        int n;
        write_frames_managed(13'd4096);
        idling_on = 1'b0;
        send_request(bfa_pkg::KIND_RELEASE, 12'd0, 13'd4096);
        @(posedge clk);
        hold_off_left = 600;
        for (n = 0; n < 30; n++)
            send_request(bfa_pkg::KIND_ALLOC, 12'd0, 13'($urandom_range(1, 4)));
        wait_results_drained();
        idling_on = 1'b1;
    endtask

    // one random request, mostly well-formed for the current managed count
    task automatic send_random_request(input int lim);
        int         pick;
        int         n;
        int         sel;
        logic [1:0]  kind;
        logic [11:0] idx;
        logic [12:0] cnt;
        pick = $urandom_range(0, 99);
        idx  = 12'($urandom_range(0, lim > 0 ? lim - 1 : 0));
        cnt  = 13'($urandom_range(1, 8));
        if (pick < 40)
        begin
            kind = bfa_pkg::KIND_ALLOC;
            n = $urandom_range(0, 19);
            if (n == 0)
                cnt = 13'($urandom_range(0, 8191));
            else if (n < 4)
                cnt = 13'($urandom_range(9, 200));
        end
        else if (pick < 70)
        begin
            // mostly frees of frames handed out earlier
            kind = bfa_pkg::KIND_FREE;
            if (allocated_starts.size() > 0 && $urandom_range(0, 9) < 7)
            begin
                sel = $urandom_range(0, allocated_starts.size() - 1);
                idx = 12'(allocated_starts[sel]);
                allocated_starts.delete(sel);
            end
        end
        else if (pick < 95)
        begin
            kind = (pick < 85) ? bfa_pkg::KIND_RELEASE : bfa_pkg::KIND_RESERVE;
            cnt  = 13'($urandom_range(0, 24));
        end
        else
        begin
            // noise over the whole field ranges
            kind = 2'($urandom_range(0, 3));
            idx  = 12'($urandom_range(0, 4095));
            cnt  = 13'($urandom_range(0, 8191));
        end
        send_request(kind, idx, cnt);
    endtask

    // random traffic over several managed counts, each phase opening the map
    task automatic test_random_traffic();
        int phase;
        int n;
        int lim;
        int managed_list[7];
        managed_list = '{4096, 64, 1, 8191, 4000, 0, 4096};
        managed_list[5] = $urandom_range(2, 4096);
        for (phase = 0; phase < 7; phase++)
        begin
            write_frames_managed(13'(managed_list[phase]));
            lim = (managed_list[phase] > NUM_FRAMES) ? NUM_FRAMES : managed_list[phase];
            // one phase without any idling on either side
            idling_on = (phase != 4);
            send_request(bfa_pkg::KIND_RELEASE, 12'd0, 13'(lim));
            for (n = 0; n < PHASE_ITEMS; n++)
                send_random_request(lim);
            wait_results_drained();
        end
        idling_on = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial
    begin
        frames_in_use = '1;
        frames_managed_cfg = int'(bfa_pkg::FRAMES_MANAGED_RST);
        idling_on = 1'b1;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        test_reset_state();
        test_config_extremes();
        test_result_backpressure();
        test_random_traffic();

        // let any stray result show up
        repeat (200) @(negedge clk);
        $display("covered %0d requests and %0d results over %0d register settings",
                 requests_sent, results_checked, settings_used);
        $display("including a long result stall and a phase without idle cycles");
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
